// ===== rtl/seeded_pair_shuffle_defines.svh =====
// Assertion macros for the seeded pair shuffle checker.
// Used by the port checker only; needs signals named clock and reset in scope.
`ifndef SEEDED_PAIR_SHUFFLE_DEFINES_SVH
`define SEEDED_PAIR_SHUFFLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SPS_CHECK_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("sps_check: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SPS_CHECK_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("sps_check: next-cycle property failed");

`endif

// ===== rtl/sps_pkg.sv =====
// Shared constants, types and helpers for the seeded pair shuffle.
// No dependencies; used by every RTL module of the block but the port checker.
package sps_pkg;

   localparam int MAX_PAIRS = 64;
   localparam int IDX_W     = $clog2(MAX_PAIRS);
   localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
   localparam int REM_W     = IDX_W + 1;

   localparam int WORD_W    = 64;
   localparam int DIGIT_W   = 8;
   localparam int MOD_STEPS = WORD_W / DIGIT_W;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   localparam logic [WORD_W-1:0] SEED_HIGH = 64'd534613516;
   localparam int ROT_LOW   = 24;
   localparam int SHIFT_MIX = 16;
   localparam int ROT_HIGH  = 37;
   localparam int ROT_RES   = 7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISCARD,
      ST_DRAW,
      ST_MUL,
      ST_MOD,
      ST_READ,
      ST_WR_I,
      ST_WR_J,
      ST_EMIT
   } sps_state_type;

   typedef struct packed {
      logic accept;
      logic seed;
      logic gen_step;
      logic mod_start;
      logic swap_read;
      logic wr_i;
      logic wr_j;
      logic emit_read;
   } sps_cmd_type;

   typedef struct packed {
      logic idx_zero;
      logic idx_one;
      logic mod_done;
      logic emit_last;
   } sps_stat_type;

   function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int s);
      return (v << s) | (v >> (WORD_W - s));
   endfunction

endpackage

// ===== rtl/sps_mod.sv =====
// Iterative 64-bit modulo by the set size, one byte of the dividend per cycle.
// Depends on sps_pkg.
module sps_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sps_pkg::WORD_W-1:0]    dividend,
   input  logic [sps_pkg::CNT_W-1:0]     divisor,
   output logic                          done,
   output logic [sps_pkg::IDX_W-1:0]     rem
);

   logic                          run_ff, run_in;
   logic [sps_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [sps_pkg::WORD_W-1:0]    div_ff, div_in;
   logic [sps_pkg::IDX_W-1:0]     rem_ff, rem_in;
   logic [sps_pkg::IDX_W-1:0]     part_rem;
   logic [sps_pkg::REM_W-1:0]     part_wide;

   assign done = run_ff && (step_ff == sps_pkg::STEP_W'(sps_pkg::MOD_STEPS - 1));
   assign rem  = rem_ff;

   // restoring remainder over the top byte of the dividend
   always_comb begin
      part_rem  = rem_ff;
      part_wide = '0;
      for (int b = 0; b < sps_pkg::DIGIT_W; b++) begin
         part_wide = {part_rem, div_ff[sps_pkg::WORD_W-1-b]};
         if (part_wide >= sps_pkg::REM_W'(divisor)) begin
            part_wide = part_wide - sps_pkg::REM_W'(divisor);
         end
         part_rem = part_wide[sps_pkg::IDX_W-1:0];
      end
   end

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         div_in  = dividend;
         rem_in  = '0;
      end else if (run_ff) begin
         step_in = step_ff + sps_pkg::STEP_W'(1);
         div_in  = div_ff << sps_pkg::DIGIT_W;
         rem_in  = part_rem;
         if (done) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

endmodule

// ===== rtl/sps_datapath.sv =====
// Datapath: pair memory, set counters, generator and output registers.
// Depends on sps_pkg and sps_mod; driven by commands from sps_ctrl.
module sps_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sps_pkg::sps_cmd_type   cmd,
   output sps_pkg::sps_stat_type  stat,
   input  logic [31:0]            pixel_index,
   input  logic [31:0]            sample_a,
   input  logic [31:0]            sample_b,
   output logic                   rsp_strobe,
   output logic [31:0]            out_a,
   output logic [31:0]            out_b,
   output logic                   final_pair
);

   logic [sps_pkg::WORD_W-1:0]  pair_mem_ff [sps_pkg::MAX_PAIRS];

   logic [sps_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [sps_pkg::CNT_W-1:0]   n_ff, n_in;
   logic [sps_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [sps_pkg::WORD_W-1:0]  gen_lo_ff, gen_lo_in;
   logic [sps_pkg::WORD_W-1:0]  gen_hi_ff, gen_hi_in;
   logic [sps_pkg::WORD_W-1:0]  lo5_ff, lo5_in;
   logic [sps_pkg::WORD_W-1:0]  rd_a_ff, rd_b_ff;
   logic                        strobe_ff, strobe_in;
   logic                        final_ff, final_in;

   logic                        store_full;
   logic [sps_pkg::CNT_W-1:0]   count_inc;
   logic [sps_pkg::WORD_W-1:0]  gen_t;
   logic [sps_pkg::WORD_W-1:0]  draw_rot;
   logic [sps_pkg::WORD_W-1:0]  draw_res;
   logic [sps_pkg::IDX_W-1:0]   mod_rem;
   logic                        mod_done;
   logic [sps_pkg::IDX_W-1:0]   j_idx;
   logic                        emit_last;
   logic                        mem_we;
   logic [sps_pkg::IDX_W-1:0]   mem_addr;
   logic [sps_pkg::WORD_W-1:0]  mem_data;

   assign store_full = (count_ff == sps_pkg::CNT_W'(sps_pkg::MAX_PAIRS));
   assign count_inc  = store_full ? count_ff : count_ff + sps_pkg::CNT_W'(1);
   assign emit_last  = ((sps_pkg::CNT_W'(idx_ff) + sps_pkg::CNT_W'(1)) == n_ff);
   assign j_idx      = mod_rem & ~(sps_pkg::IDX_W'(1));

   // draw result: rotl(lo*5, 7) * 9, the x5 already registered
   assign draw_rot = sps_pkg::rotl64(lo5_ff, sps_pkg::ROT_RES);
   assign draw_res = draw_rot + (draw_rot << 3);
   assign gen_t    = gen_hi_ff ^ gen_lo_ff;

   sps_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_start),
      .dividend (draw_res),
      .divisor  (n_ff),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   always_comb begin
      stat.idx_zero  = (idx_ff == '0);
      stat.idx_one   = (idx_ff == sps_pkg::IDX_W'(1));
      stat.mod_done  = mod_done;
      stat.emit_last = emit_last;
   end

   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      if (cmd.accept) begin
         count_in = count_inc;
      end
      if (cmd.seed) begin
         n_in   = count_inc;
         idx_in = sps_pkg::IDX_W'(count_inc - sps_pkg::CNT_W'(1));
      end else if (cmd.wr_j) begin
         idx_in = idx_ff - sps_pkg::IDX_W'(1);
      end else if (cmd.emit_read) begin
         idx_in = idx_ff + sps_pkg::IDX_W'(1);
      end
      if (cmd.emit_read && emit_last) begin
         count_in = '0;
      end
   end

   always_comb begin
      gen_lo_in = gen_lo_ff;
      gen_hi_in = gen_hi_ff;
      lo5_in    = lo5_ff;
      if (cmd.seed) begin
         gen_lo_in = {32'd0, pixel_index};
         gen_hi_in = sps_pkg::SEED_HIGH;
      end else if (cmd.gen_step) begin
         gen_lo_in = sps_pkg::rotl64(gen_lo_ff, sps_pkg::ROT_LOW) ^ gen_t
                     ^ (gen_t << sps_pkg::SHIFT_MIX);
         gen_hi_in = sps_pkg::rotl64(gen_t, sps_pkg::ROT_HIGH);
         lo5_in    = gen_lo_ff + (gen_lo_ff << 2);
      end
   end

   always_comb begin
      strobe_in = cmd.emit_read;
      final_in  = cmd.emit_read && emit_last;
   end

   // single write port: load, then the two halves of a swap
   always_comb begin
      mem_we   = (cmd.accept && !store_full) || cmd.wr_i || cmd.wr_j;
      mem_addr = count_ff[sps_pkg::IDX_W-1:0];
      mem_data = {sample_a, sample_b};
      if (cmd.wr_i) begin
         mem_addr = idx_ff;
         mem_data = rd_b_ff;
      end else if (cmd.wr_j) begin
         mem_addr = j_idx;
         mem_data = rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pair_mem_ff[mem_addr] <= mem_data;
      end
      if (cmd.swap_read || cmd.emit_read) begin
         rd_a_ff <= pair_mem_ff[idx_ff];
         rd_b_ff <= pair_mem_ff[j_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      gen_lo_ff <= gen_lo_in;
      gen_hi_ff <= gen_hi_in;
      lo5_ff    <= lo5_in;
      final_ff  <= final_in;
   end

   assign rsp_strobe = strobe_ff;
   assign out_a      = rd_a_ff[63:32];
   assign out_b      = rd_a_ff[31:0];
   assign final_pair = final_ff;

endmodule

// ===== rtl/sps_ctrl.sv =====
// Controller state machine: load, seed, per-swap sequencing and emission.
// Depends on sps_pkg; drives sps_datapath through command and status structs.
module sps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   set_end,
   input  sps_pkg::sps_stat_type  stat,
   output sps_pkg::sps_cmd_type   cmd,
   output logic                   busy
);

   sps_pkg::sps_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sps_pkg::ST_IDLE: begin
            if (start && set_end) begin
               state_in = sps_pkg::ST_DISCARD;
            end
         end
         sps_pkg::ST_DISCARD: begin
            state_in = stat.idx_zero ? sps_pkg::ST_EMIT : sps_pkg::ST_DRAW;
         end
         sps_pkg::ST_DRAW: state_in = sps_pkg::ST_MUL;
         sps_pkg::ST_MUL:  state_in = sps_pkg::ST_MOD;
         sps_pkg::ST_MOD: begin
            if (stat.mod_done) begin
               state_in = sps_pkg::ST_READ;
            end
         end
         sps_pkg::ST_READ: state_in = sps_pkg::ST_WR_I;
         sps_pkg::ST_WR_I: state_in = sps_pkg::ST_WR_J;
         sps_pkg::ST_WR_J: begin
            state_in = stat.idx_one ? sps_pkg::ST_EMIT : sps_pkg::ST_DRAW;
         end
         sps_pkg::ST_EMIT: begin
            if (stat.emit_last) begin
               state_in = sps_pkg::ST_IDLE;
            end
         end
         default: state_in = sps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         sps_pkg::ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
            cmd.seed   = start && set_end;
         end
         sps_pkg::ST_DISCARD: cmd.gen_step  = 1'b1;
         sps_pkg::ST_DRAW:    cmd.gen_step  = 1'b1;
         sps_pkg::ST_MUL:     cmd.mod_start = 1'b1;
         sps_pkg::ST_MOD:     cmd           = '0;
         sps_pkg::ST_READ:    cmd.swap_read = 1'b1;
         sps_pkg::ST_WR_I:    cmd.wr_i      = 1'b1;
         sps_pkg::ST_WR_J:    cmd.wr_j      = 1'b1;
         sps_pkg::ST_EMIT:    cmd.emit_read = 1'b1;
         default:             cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/seeded_pair_shuffle.sv =====
// Top level of the seeded pair shuffle: controller plus datapath.
// Depends on sps_pkg, sps_ctrl, sps_datapath (and sps_mod below it).
//
// Usage: drive start with one pair item (req_sample_a/b); an item is taken on
// a clock edge with start high and busy low. Items of a set load one per cycle
// with busy staying low. The item with req_set_end high closes the set; its
// req_pixel_index seeds the generator and busy rises. Pairs beyond 64 are
// dropped, though a set_end on such an item still closes the set.
// After the closing item the block makes one discarded draw, then runs N-1
// swaps, each a generator step, the x9 multiply, the byte-serial modulo, a
// read and two single-port writes, before emission. The N pairs then come
// out one per cycle on rsp_strobe with rsp_out_a/rsp_out_b, rsp_final_pair
// high on the last. busy drops as the last pair is read, so a new set may
// load while it is shown.
// The modulo unit and the single write port set the swap time.
// Results are shown for exactly one cycle; the receiver cannot hold them.
// Synchronous active-high reset returns to idle with an empty set.
module seeded_pair_shuffle (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pixel_index,
   input  logic [31:0] req_sample_a,
   input  logic [31:0] req_sample_b,
   input  logic        req_set_end,
   output logic        rsp_strobe,
   output logic [31:0] rsp_out_a,
   output logic [31:0] rsp_out_b,
   output logic        rsp_final_pair
);

   sps_pkg::sps_cmd_type  cmd;
   sps_pkg::sps_stat_type stat;

   sps_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .set_end (req_set_end),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   sps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .pixel_index (req_pixel_index),
      .sample_a    (req_sample_a),
      .sample_b    (req_sample_b),
      .rsp_strobe  (rsp_strobe),
      .out_a       (rsp_out_a),
      .out_b       (rsp_out_b),
      .final_pair  (rsp_final_pair)
   );

endmodule

// ===== rtl/sps_check.sv =====
// Port-level checker for the seeded pair shuffle, bound to the top level.
// Depends on seeded_pair_shuffle_defines.svh for the assertion macros.
`include "seeded_pair_shuffle_defines.svh"

module sps_check (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_set_end,
   input logic rsp_strobe,
   input logic rsp_final_pair
);

   // loading an item that does not close the set keeps the block open
   `SPS_CHECK_NEXT(a_load_stays_idle, start && !busy && !req_set_end, !busy)

   // closing item always starts the shuffle
   `SPS_CHECK_NEXT(a_close_goes_busy, start && !busy && req_set_end, busy)

   // while more pairs of the set are coming the block stays busy
   `SPS_CHECK_NOW(a_emit_holds_busy, rsp_strobe && !rsp_final_pair, busy)

   // an idle cycle is never followed by a result
   `SPS_CHECK_NEXT(a_idle_no_result, !busy, !rsp_strobe)

endmodule

bind seeded_pair_shuffle sps_check u_sps_check (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_set_end    (req_set_end),
   .rsp_strobe     (rsp_strobe),
   .rsp_final_pair (rsp_final_pair)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for seeded_pair_shuffle: loads sets of sample pairs, predicts the
// shuffled order with a local generator model and checks every emitted pair.
// Depends on sps_pkg and the seeded_pair_shuffle RTL.
module tb;

   localparam int          PAIR_SLOTS    = sps_pkg::MAX_PAIRS;
   localparam logic [63:0] SEED_WORD     = 64'd534613516;
   localparam int          STALL_LIMIT   = 4000;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          RANDOM_ITEMS  = 8;
   localparam int          MAX_PRINTS    = 40;

   typedef struct {
      logic [31:0] a;
      logic [31:0] b;
      logic        closing;
   } shuffled_pair_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_pixel_index;
   logic [31:0] req_sample_a;
   logic [31:0] req_sample_b;
   logic        req_set_end;
   logic        rsp_strobe;
   logic [31:0] rsp_out_a;
   logic [31:0] rsp_out_b;
   logic        rsp_final_pair;

   seeded_pair_shuffle dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel_index (req_pixel_index),
      .req_sample_a    (req_sample_a),
      .req_sample_b    (req_sample_b),
      .req_set_end     (req_set_end),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_a       (rsp_out_a),
      .rsp_out_b       (rsp_out_b),
      .rsp_final_pair  (rsp_final_pair)
   );

   // local copy of the block's set store and generator
   logic [31:0]       held_a [PAIR_SLOTS];
   logic [31:0]       held_b [PAIR_SLOTS];
   int                held_n;
   logic [63:0]       rng_lo;
   logic [63:0]       rng_hi;
   shuffled_pair_type pending_pairs [$];

   int err_count;
   int results_seen;
   int stall_cycles;
   bit gaps_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("ERROR @%0t result %0d: %s got %h want %h",
                  $realtime, results_seen, what, got, want);
   endtask

   function automatic logic [63:0] rng_draw();
      logic [63:0] lo;
      logic [63:0] t;
      logic [63:0] m;
      logic [63:0] res;
      lo     = rng_lo;
      t      = rng_hi ^ lo;
      m      = lo * 64'd5;
      res    = {m[56:0], m[63:57]} * 64'd9;
      rng_lo = {lo[39:0], lo[63:40]} ^ t ^ (t << 16);
      rng_hi = {t[26:0], t[63:27]};
      return res;
   endfunction

   // Stores one accepted pair; on the closing item shuffles the set and queues it.
   function automatic void load_and_shuffle(input logic [31:0] pix, input logic [31:0] a,
                                            input logic [31:0] b, input logic closes);
      int          n;
      int          j;
      logic [63:0] r;
      logic [31:0] ta;
      logic [31:0] tb_word;
      if (held_n < PAIR_SLOTS) begin
         held_a[held_n] = a;
         held_b[held_n] = b;
         held_n++;
      end
      if (!closes)
         return;
      n      = held_n;
      rng_lo = {32'd0, pix};
      rng_hi = SEED_WORD;
      void'(rng_draw());
      for (int i = n - 1; i > 0; i--) begin
         r = rng_draw();
         // partner index is forced even
         j = int'(r % 64'(n)) & ~1;
         ta        = held_a[i];
         tb_word   = held_b[i];
         held_a[i] = held_a[j];
         held_b[i] = held_b[j];
         held_a[j] = ta;
         held_b[j] = tb_word;
      end
      for (int i = 0; i < n; i++)
         pending_pairs.push_back('{held_a[i], held_b[i], (i == n - 1)});
      held_n = 0;
   endfunction

   // Leaves start high on return so the next item can follow without a gap.
   task automatic send_pair(input logic [31:0] pix, input logic [31:0] a,
                            input logic [31:0] b, input logic closes);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 13) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_pixel_index <= pix;
      req_sample_a    <= a;
      req_sample_b    <= b;
      req_set_end     <= closes;
      do
         @(posedge clock);
      while (busy);
      load_and_shuffle(pix, a, b, closes);
   endtask

   task automatic send_set(input int size, input logic [31:0] pix);
      for (int k = 0; k < size; k++)
         send_pair((k == size - 1) ? pix : $urandom(), $urandom(), $urandom(),
                   (k == size - 1));
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pairs.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("unexpected item, out_a", rsp_out_a, 32'd0);
         end else begin
            shuffled_pair_type want;
            want = pending_pairs.pop_front();
            if (rsp_out_a !== want.a)
               report_mismatch("out_a", rsp_out_a, want.a);
            if (rsp_out_b !== want.b)
               report_mismatch("out_b", rsp_out_b, want.b);
            if (rsp_final_pair !== want.closing)
               report_mismatch("final_pair", {31'd0, rsp_final_pair}, {31'd0, want.closing});
         end
         results_seen++;
      end
   end

   // During a 64-pair shuffle nothing moves on the ports until the pairs come out.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic test_single_pair();
      send_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
      wait_results_drained();
   endtask

   task automatic test_field_extremes();
      send_pair(32'd0, 32'd0, 32'd0, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_pair(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
      send_set(2, 32'd0);
      wait_results_drained();
   endtask

   task automatic test_small_sets();
      send_set(3, 32'd1);
      send_set(5, 32'h8000_0000);
      wait_results_drained();
   endtask

   task automatic test_full_store();
      send_set(PAIR_SLOTS, $urandom());
      wait_results_drained();
   endtask

   // set_end on a pair that no longer fits still closes the set
   task automatic test_overflow_drop();
      send_set(PAIR_SLOTS + 2, 32'hFFFF_FFFF);
      wait_results_drained();
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      send_set(3, $urandom());
      send_set(1, $urandom());
      send_set(7, $urandom());
      send_set(2, $urandom());
      send_set(5, $urandom());
      gaps_on = 1'b1;
      wait_results_drained();
   endtask

   task automatic test_random_sets();
      int          loaded;
      int          size;
      int          pick;
      logic [31:0] pix;
      loaded = 0;
      while (loaded < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 75)
            size = $urandom_range(6, 1);
         else
            size = $urandom_range(12, 7);
         pick = $urandom_range(9);
         pix  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
         if ($urandom_range(19) == 0)
            wait_results_drained();
         send_set(size, pix);
         loaded += size;
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_pixel_index = 32'd0;
      req_sample_a    = 32'd0;
      req_sample_b    = 32'd0;
      req_set_end     = 1'b0;
      gaps_on         = 1'b1;
      err_count       = 0;
      results_seen    = 0;
      stall_cycles    = 0;
      held_n          = 0;
      rng_lo          = 64'd0;
      rng_hi          = 64'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_pair();
      test_field_extremes();
      test_small_sets();
      test_full_store();
      test_overflow_drop();
      test_back_to_back();
      test_random_sets();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_mod.sv
rtl/sps_datapath.sv
rtl/sps_ctrl.sv
rtl/seeded_pair_shuffle.sv
rtl/sps_check.sv
tb/tb.sv
